// File: rtl/drt_pkg.sv
`default_nettype none

package drt_pkg;

  // Sizing
  localparam int MAX_ENTITIES = 64;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_W      = 16;
  localparam int HANDLE_W     = 7;
  localparam int DIM_W        = 15;
  localparam int ENT_AW       = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int ENT_CW       = $clog2(MAX_ENTITIES + 1);
  localparam int COUNT_W      = 7;
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
  localparam int FULLSCREEN_FRAMES = 2;

  // Request modes
  localparam logic [1:0] MODE_SET      = 2'd0;
  localparam logic [1:0] MODE_CLEAR    = 2'd1;
  localparam logic [1:0] MODE_RETRIEVE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_VIEW_W        = 2'd0;
  localparam logic [1:0] CFG_VIEW_H        = 2'd1;
  localparam logic [1:0] CFG_ENTITY_COUNT  = 2'd2;

  // Dirty mark bits
  localparam int DIRTY_NOW = 0;
  localparam int DIRTY_P0  = 1;
  localparam int DIRTY_P1  = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } rect_t;

  typedef struct packed {
    logic [2:0] dirty;
    rect_t      rect;
  } cur_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_SCAN_END
  } state_t;

  // Screen size saturated to the largest positive coordinate
  function automatic coord_t screen_dim(input logic [DIM_W-1:0] d);
    logic [31:0] dw;
    dw = 32'(d);
    if (dw > 32'(COORD_MAX)) begin
      return coord_t'(COORD_MAX);
    end
    return coord_t'(dw);
  endfunction

  function automatic logic rect_empty(input rect_t r);
    return (r.x0 >= r.x1) || (r.y0 >= r.y1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/dirty_rectangle_tracker_top.sv
`default_nettype none

// Dirty rectangle tracker for a double-buffered display.
// Request channel: a request is taken at a clock edge with start high and
// busy low. mode selects set rectangle, set empty, or retrieve; handle
// picks entity 1..64 for updates (others, and mode 3, are dropped).
// Result channel: result_strobe marks each result for exactly one cycle;
// the receiver cannot stall it. last flags the final result of a retrieve.
// Config: cfg_we/cfg_index/cfg_data write width, height and entity count.
// Sequence: an update is accepted, then reads and writes back the entity
// memory. The first two retrieves after reset return the full screen in the
// cycle after accept and free the block at once. A scan retrieve passes
// each scanned entity through a memory read state and a modify/write state,
// then an end state, with one result held back so the final one can carry
// last; results never come out back to back, except that the final one can
// follow the one before it directly.
// busy stays high until the last result is registered.
// Reset (synchronous, active high) clears per-entry valid flops, so all
// entity state reads as empty and clean right away; parity goes to 0.

module dirty_rectangle_tracker_top (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [1:0]                            mode,
  input  wire  [drt_pkg::HANDLE_W-1:0]          handle,
  input  wire  signed [drt_pkg::FIELD_W-1:0]    rect_min_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]    rect_min_y,
  input  wire  signed [drt_pkg::FIELD_W-1:0]    rect_max_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]    rect_max_y,
  input  wire                                   cfg_we,
  input  wire  [1:0]                            cfg_index,
  input  wire  [drt_pkg::DIM_W-1:0]             cfg_data,
  output logic                                  result_strobe,
  output logic signed [drt_pkg::FIELD_W-1:0]    out_min_x,
  output logic signed [drt_pkg::FIELD_W-1:0]    out_min_y,
  output logic signed [drt_pkg::FIELD_W-1:0]    out_max_x,
  output logic signed [drt_pkg::FIELD_W-1:0]    out_max_y,
  output logic                                  rect_valid,
  output logic                                  last
);

  localparam int PREV_DEPTH = 2 * drt_pkg::MAX_ENTITIES;

  // Configuration registers
  logic [drt_pkg::DIM_W-1:0]   view_w;
  logic [drt_pkg::DIM_W-1:0]   view_h;
  logic [drt_pkg::COUNT_W-1:0] entity_count;

  // Control state
  drt_pkg::state_t             state, state_next;
  logic                        parity;
  logic [1:0]                  fs_left;
  logic [drt_pkg::ENT_AW-1:0]  idx;
  logic [drt_pkg::ENT_AW-1:0]  upd_addr;
  drt_pkg::rect_t              upd_rect;
  drt_pkg::rect_t              pend_rect;
  logic                        pend_vld;

  // Memories and their valid flops
  drt_pkg::cur_entry_t         cur_mem [drt_pkg::MAX_ENTITIES];
  drt_pkg::rect_t              prev_mem [PREV_DEPTH];
  logic [drt_pkg::MAX_ENTITIES-1:0] cur_vld;
  logic [PREV_DEPTH-1:0]       prev_vld;
  drt_pkg::cur_entry_t         cur_rd;
  drt_pkg::rect_t              prev_rd;
  logic                        cur_rd_vld;
  logic                        prev_rd_vld;
  drt_pkg::cur_entry_t         cur_q;
  drt_pkg::rect_t              prev_q;

  // Combinational control
  logic                        accept;
  logic                        handle_ok;
  logic                        is_upd;
  logic                        is_ret;
  logic [drt_pkg::ENT_CW-1:0]  scan_n;
  logic                        scan_done;
  logic [drt_pkg::ENT_AW-1:0]  cur_addr;
  logic [drt_pkg::ENT_AW:0]    prev_addr;
  logic                        cur_re, cur_we, prev_re, prev_we;
  drt_pkg::cur_entry_t         cur_wd;
  logic                        pbit, hit, found;
  logic [2:0]                  dirty_new;
  logic                        emit;
  drt_pkg::rect_t              emit_rect;
  logic                        emit_valid, emit_last;
  drt_pkg::rect_t              clip_rect;
  drt_pkg::coord_t             dim_w, dim_h;
  drt_pkg::coord_t             in_x0, in_y0, in_x1, in_y1;

  assign busy = (state != drt_pkg::ST_IDLE);

  // Request decode
  assign accept    = start && !busy;
  assign handle_ok = (handle != '0) &&
                     (handle <= drt_pkg::HANDLE_W'(drt_pkg::MAX_ENTITIES));
  assign is_upd    = ((mode == drt_pkg::MODE_SET) || (mode == drt_pkg::MODE_CLEAR)) &&
                     handle_ok;
  assign is_ret    = (mode == drt_pkg::MODE_RETRIEVE);
  assign scan_n    = (entity_count > drt_pkg::COUNT_W'(drt_pkg::MAX_ENTITIES)) ?
                     drt_pkg::ENT_CW'(drt_pkg::MAX_ENTITIES) :
                     drt_pkg::ENT_CW'(entity_count);
  assign scan_done = (drt_pkg::ENT_CW'(idx) == scan_n - drt_pkg::ENT_CW'(1));

  // Clip incoming rectangle to the screen
  assign dim_w = drt_pkg::screen_dim(view_w);
  assign dim_h = drt_pkg::screen_dim(view_h);
  assign in_x0 = rect_min_x[drt_pkg::COORD_BITS-1:0];
  assign in_y0 = rect_min_y[drt_pkg::COORD_BITS-1:0];
  assign in_x1 = rect_max_x[drt_pkg::COORD_BITS-1:0];
  assign in_y1 = rect_max_y[drt_pkg::COORD_BITS-1:0];

  always_comb begin
    if (mode == drt_pkg::MODE_SET) begin
      clip_rect.x0 = (in_x0 < 0) ? '0 : in_x0;
      clip_rect.y0 = (in_y0 < 0) ? '0 : in_y0;
      clip_rect.x1 = (in_x1 < dim_w) ? in_x1 : dim_w;
      clip_rect.y1 = (in_y1 < dim_h) ? in_y1 : dim_h;
    end else begin
      clip_rect = '0;
    end
  end

  // Memory read data, masked by the entry valid flops
  assign cur_q  = cur_rd_vld ? cur_rd : '0;
  assign prev_q = prev_rd_vld ? prev_rd : '0;

  // Scan step: dirty test and new marks
  assign pbit  = parity ? cur_q.dirty[drt_pkg::DIRTY_P1] : cur_q.dirty[drt_pkg::DIRTY_P0];
  assign hit   = cur_q.dirty[drt_pkg::DIRTY_NOW] || pbit;
  assign found = hit && !drt_pkg::rect_empty(prev_q);

  always_comb begin
    dirty_new = cur_q.dirty;
    dirty_new[drt_pkg::DIRTY_NOW] = 1'b0;
    if (parity) begin
      dirty_new[drt_pkg::DIRTY_P1] = cur_q.dirty[drt_pkg::DIRTY_NOW];
    end else begin
      dirty_new[drt_pkg::DIRTY_P0] = cur_q.dirty[drt_pkg::DIRTY_NOW];
    end
  end

  assign cur_addr  = (state == drt_pkg::ST_UPD_RD || state == drt_pkg::ST_UPD_WR) ?
                     upd_addr : idx;
  assign prev_addr = {idx, parity};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      drt_pkg::ST_IDLE: begin
        if (accept && is_upd) begin
          state_next = drt_pkg::ST_UPD_RD;
        end else if (accept && is_ret && fs_left == '0) begin
          state_next = (scan_n == '0) ? drt_pkg::ST_SCAN_END : drt_pkg::ST_SCAN_RD;
        end
      end
      drt_pkg::ST_UPD_RD:   state_next = drt_pkg::ST_UPD_WR;
      drt_pkg::ST_UPD_WR:   state_next = drt_pkg::ST_IDLE;
      drt_pkg::ST_SCAN_RD:  state_next = drt_pkg::ST_SCAN_WR;
      drt_pkg::ST_SCAN_WR:  state_next = scan_done ? drt_pkg::ST_SCAN_END :
                                                     drt_pkg::ST_SCAN_RD;
      drt_pkg::ST_SCAN_END: state_next = drt_pkg::ST_IDLE;
      default:              state_next = drt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory strobes and result selection
  always_comb begin
    cur_re     = 1'b0;
    cur_we     = 1'b0;
    prev_re    = 1'b0;
    prev_we    = 1'b0;
    cur_wd     = cur_q;
    emit       = 1'b0;
    emit_rect  = pend_rect;
    emit_valid = 1'b1;
    emit_last  = 1'b0;
    case (state)
      drt_pkg::ST_IDLE: begin
        if (accept && is_ret && fs_left != '0) begin
          emit           = 1'b1;
          emit_rect.x0   = '0;
          emit_rect.y0   = '0;
          emit_rect.x1   = dim_w;
          emit_rect.y1   = dim_h;
          emit_last      = 1'b1;
        end
      end
      drt_pkg::ST_UPD_RD: begin
        cur_re = 1'b1;
      end
      drt_pkg::ST_UPD_WR: begin
        cur_we       = 1'b1;
        cur_wd.rect  = upd_rect;
        cur_wd.dirty = cur_q.dirty | 3'b001;
      end
      drt_pkg::ST_SCAN_RD: begin
        cur_re  = 1'b1;
        prev_re = 1'b1;
      end
      drt_pkg::ST_SCAN_WR: begin
        cur_we       = hit;
        prev_we      = hit;
        cur_wd.dirty = dirty_new;
        emit         = found && pend_vld;
      end
      drt_pkg::ST_SCAN_END: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (!pend_vld) begin
          emit_rect  = '0;
          emit_valid = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // State register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= drt_pkg::ST_IDLE;
      parity   <= 1'b0;
      fs_left  <= 2'(drt_pkg::FULLSCREEN_FRAMES);
      idx      <= '0;
      pend_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        drt_pkg::ST_IDLE: begin
          idx      <= '0;
          pend_vld <= 1'b0;
          if (accept && is_ret && fs_left != '0) begin
            fs_left <= fs_left - 2'd1;
            parity  <= ~parity;
          end
        end
        drt_pkg::ST_SCAN_WR: begin
          idx <= idx + drt_pkg::ENT_AW'(1);
          if (found) begin
            pend_vld <= 1'b1;
          end
        end
        drt_pkg::ST_SCAN_END: begin
          parity   <= ~parity;
          pend_vld <= 1'b0;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Update request payload and held-back result
  always_ff @(posedge clk) begin
    if (state == drt_pkg::ST_IDLE && accept) begin
      upd_addr <= drt_pkg::ENT_AW'(handle - drt_pkg::HANDLE_W'(1));
      upd_rect <= clip_rect;
    end
    if (state == drt_pkg::ST_SCAN_WR && found) begin
      pend_rect <= prev_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_w       <= drt_pkg::DIM_W'(320);
      view_h       <= drt_pkg::DIM_W'(240);
      entity_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        drt_pkg::CFG_VIEW_W:        view_w       <= cfg_data;
        drt_pkg::CFG_VIEW_H:        view_h       <= cfg_data;
        drt_pkg::CFG_ENTITY_COUNT:  entity_count <= cfg_data[drt_pkg::COUNT_W-1:0];
        default:                    entity_count <= entity_count;
      endcase
    end
  end

  // Current rectangle and dirty mark memory
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_addr] <= cur_wd;
    end
    if (cur_re) begin
      cur_rd <= cur_mem[cur_addr];
    end
  end

  // Per-frame remembered rectangle memory
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_addr] <= cur_q.rect;
    end
    if (prev_re) begin
      prev_rd <= prev_mem[prev_addr];
    end
  end

  // Entry valid flops; unwritten entries read as empty and clean
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld     <= '0;
      prev_vld    <= '0;
      cur_rd_vld  <= 1'b0;
      prev_rd_vld <= 1'b0;
    end else begin
      if (cur_we) begin
        cur_vld[cur_addr] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[prev_addr] <= 1'b1;
      end
      if (cur_re) begin
        cur_rd_vld <= cur_vld[cur_addr];
      end
      if (prev_re) begin
        prev_rd_vld <= prev_vld[prev_addr];
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_min_x  <= drt_pkg::FIELD_W'(emit_rect.x0);
      out_min_y  <= drt_pkg::FIELD_W'(emit_rect.y0);
      out_max_x  <= drt_pkg::FIELD_W'(emit_rect.x1);
      out_max_y  <= drt_pkg::FIELD_W'(emit_rect.y1);
      rect_valid <= emit_valid;
      last       <= emit_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drt_checker.sv
`default_nettype none

module drt_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 start,
  input wire                                 busy,
  input wire [1:0]                           mode,
  input wire                                 result_strobe,
  input wire signed [drt_pkg::FIELD_W-1:0]   out_min_x,
  input wire signed [drt_pkg::FIELD_W-1:0]   out_min_y,
  input wire signed [drt_pkg::FIELD_W-1:0]   out_max_x,
  input wire signed [drt_pkg::FIELD_W-1:0]   out_max_y,
  input wire                                 rect_valid,
  input wire                                 last
);

  // A non-final result means the scan is still running
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("non-final result while block is free");

  // The empty-frame marker is all zero and closes the retrieve
  a_none_shape: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !rect_valid |->
      last && out_min_x == '0 && out_min_y == '0 && out_max_x == '0 && out_max_y == '0)
    else $error("malformed no-rectangle result");

  // Reported rectangles are never inverted
  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    result_strobe && rect_valid |-> out_min_x <= out_max_x && out_min_y <= out_max_y)
    else $error("inverted rectangle reported");

  // An accepted update gives no result in the next cycle
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == drt_pkg::MODE_SET || mode == drt_pkg::MODE_CLEAR)
      |=> !result_strobe)
    else $error("result after update request");

endmodule

bind dirty_rectangle_tracker_top drt_checker u_drt_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .mode          (mode),
  .result_strobe (result_strobe),
  .out_min_x     (out_min_x),
  .out_min_y     (out_min_y),
  .out_max_x     (out_max_x),
  .out_max_y     (out_max_y),
  .rect_valid    (rect_valid),
  .last          (last)
);

`default_nettype wire

// File: tb/dirty_rectangle_checker.sv
`timescale 1ns / 100ps

// Watches the request, config and result channels of the tracker, keeps its
// own copy of the entity tables and checks every redraw result in order.
module dirty_rectangle_checker (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire                                 busy,
  input  wire  [1:0]                          mode,
  input  wire  [drt_pkg::HANDLE_W-1:0]        handle,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  rect_min_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  rect_min_y,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  rect_max_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  rect_max_y,
  input  wire                                 cfg_we,
  input  wire  [1:0]                          cfg_index,
  input  wire  [drt_pkg::DIM_W-1:0]           cfg_data,
  input  wire                                 result_strobe,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  out_min_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  out_min_y,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  out_max_x,
  input  wire  signed [drt_pkg::FIELD_W-1:0]  out_max_y,
  input  wire                                 rect_valid,
  input  wire                                 last,
  output int                                  mismatch_count,
  output int                                  redraws_pending
);

  typedef struct packed {
    drt_pkg::rect_t box;
    logic           valid;
    logic           is_last;
  } redraw_t;

  // Shadow copy of the tracker state
  drt_pkg::rect_t               cur_box  [drt_pkg::MAX_ENTITIES];
  drt_pkg::rect_t               prev_box [2*drt_pkg::MAX_ENTITIES];
  logic [2:0]                   marks    [drt_pkg::MAX_ENTITIES];
  logic                         parity;
  int                           full_frames;
  logic [drt_pkg::DIM_W-1:0]    width_r;
  logic [drt_pkg::DIM_W-1:0]    height_r;
  logic [drt_pkg::COUNT_W-1:0]  count_r;

  redraw_t redraw_q[$];

  // Screen bound in coordinate units, saturated at the top coordinate
  function automatic drt_pkg::coord_t bound_of(input logic [drt_pkg::DIM_W-1:0] d);
    if (int'(d) > drt_pkg::COORD_MAX) begin
      return drt_pkg::coord_t'(drt_pkg::COORD_MAX);
    end
    return drt_pkg::coord_t'(int'(d));
  endfunction

  function automatic logic box_is_empty(input drt_pkg::rect_t b);
    return ($signed(b.x0) >= $signed(b.x1)) || ($signed(b.y0) >= $signed(b.y1));
  endfunction

  // Work out the redraw rectangles one request causes
  task automatic predict_damage(input logic [1:0] m,
                                input logic [drt_pkg::HANDLE_W-1:0] h,
                                input drt_pkg::coord_t ax0, input drt_pkg::coord_t ay0,
                                input drt_pkg::coord_t ax1, input drt_pkg::coord_t ay1);
    int              n;
    int              k;
    int              slot;
    int              idx;
    logic [2:0]      pbit;
    logic [2:0]      d;
    drt_pkg::rect_t  nb;
    redraw_t         r;
    drt_pkg::coord_t wb;
    drt_pkg::coord_t hb;
    wb = bound_of(width_r);
    hb = bound_of(height_r);
    if (m == drt_pkg::MODE_SET || m == drt_pkg::MODE_CLEAR) begin
      // bad handles are dropped
      if (h == 0 || int'(h) > drt_pkg::MAX_ENTITIES) begin
        return;
      end
      idx = int'(h) - 1;
      nb = '0;
      if (m == drt_pkg::MODE_SET) begin
        nb.x0 = ($signed(ax0) > 0) ? ax0 : drt_pkg::coord_t'(0);
        nb.y0 = ($signed(ay0) > 0) ? ay0 : drt_pkg::coord_t'(0);
        nb.x1 = ($signed(ax1) < $signed(wb)) ? ax1 : wb;
        nb.y1 = ($signed(ay1) < $signed(hb)) ? ay1 : hb;
      end
      cur_box[idx] = nb;
      marks[idx][drt_pkg::DIRTY_NOW] = 1'b1;
    end else if (m == drt_pkg::MODE_RETRIEVE) begin
      if (full_frames > 0) begin
        // startup frames repaint the whole screen
        r.box = '0;
        r.box.x1 = wb;
        r.box.y1 = hb;
        r.valid = 1'b1;
        r.is_last = 1'b1;
        redraw_q.push_back(r);
        full_frames = full_frames - 1;
        parity = ~parity;
      end else begin
        n = (int'(count_r) > drt_pkg::MAX_ENTITIES) ? drt_pkg::MAX_ENTITIES
                                                     : int'(count_r);
        pbit = '0;
        pbit[parity ? drt_pkg::DIRTY_P1 : drt_pkg::DIRTY_P0] = 1'b1;
        k = 0;
        for (int i = 0; i < n; i++) begin
          d = marks[i];
          if (!d[drt_pkg::DIRTY_NOW] && ((d & pbit) == 3'b000)) begin
            continue;
          end
          slot = 2*i + int'(parity);
          if (!box_is_empty(prev_box[slot])) begin
            r.box = prev_box[slot];
            r.valid = 1'b1;
            r.is_last = 1'b0;
            redraw_q.push_back(r);
            k++;
          end
          prev_box[slot] = cur_box[i];
          d = d & ~pbit;
          if (d[drt_pkg::DIRTY_NOW]) begin
            d = d | pbit;
          end
          d[drt_pkg::DIRTY_NOW] = 1'b0;
          marks[i] = d;
        end
        parity = ~parity;
        if (k == 0) begin
          // nothing to redraw
          r = '0;
          r.is_last = 1'b1;
          redraw_q.push_back(r);
        end else begin
          r = redraw_q.pop_back();
          r.is_last = 1'b1;
          redraw_q.push_back(r);
        end
      end
    end
  endtask

  // Results first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin
    redraw_t want;
    redraw_t got;
    if (rst) begin
      for (int i = 0; i < drt_pkg::MAX_ENTITIES; i++) begin
        cur_box[i] = '0;
        marks[i] = '0;
        prev_box[2*i] = '0;
        prev_box[2*i+1] = '0;
      end
      parity = 1'b0;
      full_frames = drt_pkg::FULLSCREEN_FRAMES;
      width_r = drt_pkg::DIM_W'(320);
      height_r = drt_pkg::DIM_W'(240);
      count_r = '0;
      mismatch_count = 0;
      redraw_q.delete();
    end else begin
      if (result_strobe) begin
        got.box.x0 = out_min_x;
        got.box.y0 = out_min_y;
        got.box.x1 = out_max_x;
        got.box.y1 = out_max_y;
        got.valid = rect_valid;
        got.is_last = last;
        if (redraw_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected redraw (%0d,%0d)-(%0d,%0d) valid %b last %b",
                     $signed(got.box.x0), $signed(got.box.y0), $signed(got.box.x1),
                     $signed(got.box.y1), got.valid, got.is_last);
          end
        end else begin
          want = redraw_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("redraw mismatch at %0t: expected (%0d,%0d)-(%0d,%0d) v%b l%b",
                       $realtime, $signed(want.box.x0), $signed(want.box.y0),
                       $signed(want.box.x1), $signed(want.box.y1), want.valid,
                       want.is_last);
              $display("  got (%0d,%0d)-(%0d,%0d) v%b l%b",
                       $signed(got.box.x0), $signed(got.box.y0), $signed(got.box.x1),
                       $signed(got.box.y1), got.valid, got.is_last);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          drt_pkg::CFG_VIEW_W: begin
            width_r = cfg_data;
          end
          drt_pkg::CFG_VIEW_H: begin
            height_r = cfg_data;
          end
          drt_pkg::CFG_ENTITY_COUNT: begin
            count_r = cfg_data[drt_pkg::COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        predict_damage(mode, handle, rect_min_x, rect_min_y, rect_max_x, rect_max_y);
      end
    end
    redraws_pending = redraw_q.size();
  end

endmodule

// File: tb/dirty_rectangle_tracker_top_tb.sv
`timescale 1ns / 100ps

module dirty_rectangle_tracker_top_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // longest scan plus margin
  localparam int HOLD_CYCLES = 2*drt_pkg::MAX_ENTITIES + 16;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [1:0]                    mode = drt_pkg::MODE_SET;
  logic [drt_pkg::HANDLE_W-1:0]  handle = '0;
  drt_pkg::coord_t               rect_min_x = '0;
  drt_pkg::coord_t               rect_min_y = '0;
  drt_pkg::coord_t               rect_max_x = '0;
  drt_pkg::coord_t               rect_max_y = '0;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = drt_pkg::CFG_VIEW_W;
  logic [drt_pkg::DIM_W-1:0]     cfg_data = '0;

  logic                          busy;
  logic                          result_strobe;
  drt_pkg::coord_t               out_min_x;
  drt_pkg::coord_t               out_min_y;
  drt_pkg::coord_t               out_max_x;
  drt_pkg::coord_t               out_max_y;
  logic                          rect_valid;
  logic                          last;

  int                            mismatch_count;
  int                            redraws_pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dirty_rectangle_tracker_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .handle        (handle),
    .rect_min_x    (rect_min_x),
    .rect_min_y    (rect_min_y),
    .rect_max_x    (rect_max_x),
    .rect_max_y    (rect_max_y),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .out_min_x     (out_min_x),
    .out_min_y     (out_min_y),
    .out_max_x     (out_max_x),
    .out_max_y     (out_max_y),
    .rect_valid    (rect_valid),
    .last          (last)
  );

  dirty_rectangle_checker damage_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .handle          (handle),
    .rect_min_x      (rect_min_x),
    .rect_min_y      (rect_min_y),
    .rect_max_x      (rect_max_x),
    .rect_max_y      (rect_max_y),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_strobe   (result_strobe),
    .out_min_x       (out_min_x),
    .out_min_y       (out_min_y),
    .out_max_x       (out_max_x),
    .out_max_y       (out_max_y),
    .rect_valid      (rect_valid),
    .last            (last),
    .mismatch_count  (mismatch_count),
    .redraws_pending (redraws_pending)
  );

  // Present one request after gap idle cycles; returns at the accepting edge.
  // busy only moves at rising edges, so its value at the falling edge is the
  // one the accepting edge sees.
  task automatic send_request(input logic [1:0] m, input logic [drt_pkg::HANDLE_W-1:0] h,
                              input drt_pkg::coord_t x0, input drt_pkg::coord_t y0,
                              input drt_pkg::coord_t x1, input drt_pkg::coord_t y1,
                              input int gap);
    logic took;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    handle <= h;
    rect_min_x <= x0;
    rect_min_y <= y0;
    rect_max_x <= x1;
    rect_max_y <= y1;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // Hold off requests until every expected redraw has come out
  task automatic wait_redraws();
    start <= 1'b0;
    do begin
      @(negedge clk);
    end while (redraws_pending != 0 || busy);
    @(posedge clk);
  endtask

  // Reprogram all three registers with the tracker idle
  task automatic write_setup(input int w, input int h, input int n);
    wait_redraws();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= drt_pkg::CFG_VIEW_W;
    cfg_data <= drt_pkg::DIM_W'(w);
    @(posedge clk);
    cfg_index <= drt_pkg::CFG_VIEW_H;
    cfg_data <= drt_pkg::DIM_W'(h);
    @(posedge clk);
    cfg_index <= drt_pkg::CFG_ENTITY_COUNT;
    cfg_data <= drt_pkg::DIM_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Edge near the screen range, so clipping is hit from both sides
  function automatic drt_pkg::coord_t near_edge(input int span);
    return drt_pkg::coord_t'(int'($urandom_range(0, span + 40)) - 20);
  endfunction

  // One random request; counted is 0 for requests the tracker just drops
  task automatic random_request(input int w, input int h, input int n, input int gap,
                                output bit counted);
    int                           r;
    int                           hmax;
    logic [1:0]                   m;
    logic [drt_pkg::HANDLE_W-1:0] hd;
    drt_pkg::coord_t              x0;
    drt_pkg::coord_t              y0;
    drt_pkg::coord_t              x1;
    drt_pkg::coord_t              y1;
    hmax = (n == 0 || n > drt_pkg::MAX_ENTITIES - 2) ? drt_pkg::MAX_ENTITIES : n + 2;
    hd = drt_pkg::HANDLE_W'($urandom_range(1, hmax));
    counted = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      m = drt_pkg::MODE_SET;
    end else if (r < 70) begin
      m = drt_pkg::MODE_CLEAR;
    end else if (r < 88) begin
      m = drt_pkg::MODE_RETRIEVE;
      hd = drt_pkg::HANDLE_W'($urandom);
    end else begin
      counted = 1'b0;
      if (r < 94) begin
        m = MODE_UNUSED;
        hd = drt_pkg::HANDLE_W'($urandom);
      end else begin
        m = $urandom_range(0, 1) ? drt_pkg::MODE_SET : drt_pkg::MODE_CLEAR;
        hd = $urandom_range(0, 1) ? drt_pkg::HANDLE_W'(0)
                                  : drt_pkg::HANDLE_W'($urandom_range(
                                        drt_pkg::MAX_ENTITIES + 1, 127));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      x0 = drt_pkg::coord_t'($urandom);
      y0 = drt_pkg::coord_t'($urandom);
      x1 = drt_pkg::coord_t'($urandom);
      y1 = drt_pkg::coord_t'($urandom);
    end else begin
      x0 = near_edge(w);
      y0 = near_edge(h);
      x1 = drt_pkg::coord_t'(int'(x0) + int'($urandom_range(0, 240)) - 20);
      y1 = drt_pkg::coord_t'(int'(y0) + int'($urandom_range(0, 240)) - 20);
    end
    send_request(m, hd, x0, y0, x1, y1, gap);
  endtask

  initial begin
    int w;
    int h;
    int n;
    int sent;
    int gap;
    bit no_gaps;
    bit counted;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: clipping at reset-time screen, bad handles, unused mode
    send_request(drt_pkg::MODE_SET, 7'd1, -16'sd32768, -16'sd32768, 16'sd32767,
                 16'sd32767, $urandom_range(0, 6));
    send_request(drt_pkg::MODE_SET, 7'd64, 16'sd10, 16'sd20, 16'sd30, 16'sd40, 0);
    send_request(drt_pkg::MODE_SET, 7'd0, 16'sd5, 16'sd5, 16'sd6, 16'sd6, 0);
    send_request(drt_pkg::MODE_SET, 7'd127, 16'sd5, 16'sd5, 16'sd6, 16'sd6, 1);
    send_request(MODE_UNUSED, 7'd2, 16'sd1, 16'sd1, 16'sd9, 16'sd9, 0);
    send_request(drt_pkg::MODE_CLEAR, 7'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    // inverted box, and a box left of the screen: both clip to empty
    send_request(drt_pkg::MODE_SET, 7'd3, 16'sd100, 16'sd100, 16'sd50, 16'sd50, 2);
    send_request(drt_pkg::MODE_SET, 7'd4, -16'sd100, -16'sd5, -16'sd1, 16'sd10, 0);

    // Zero-width screen: clipped boxes are empty, full-screen result keeps zero
    write_setup(0, 32767, 0);
    send_request(drt_pkg::MODE_SET, 7'd5, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 3);

    // Second full-screen frame, then the scan takes over
    write_setup(32767, 1, 64);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_SET, 7'd1, 16'sd1, -16'sd1, 16'sd32767, 16'sd32767, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_CLEAR, 7'd64, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(drt_pkg::MODE_RETRIEVE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);

    // Random phases, each with its own screen and entity count
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          w = 32767; h = 32767; n = 64;
        end
        1: begin
          w = 1; h = 1; n = 1;
        end
        2: begin
          w = 0; h = 0; n = 5;
        end
        3: begin
          // count above the table size is capped
          w = $urandom_range(1, 400); h = $urandom_range(1, 300); n = 127;
        end
        4: begin
          w = $urandom_range(1, 400); h = $urandom_range(1, 300); n = 0;
        end
        5: begin
          w = 320; h = 240; n = 8;
        end
        default: begin
          w = $urandom_range(1, 400); h = $urandom_range(1, 300);
          n = $urandom_range(1, 8);
        end
      endcase
      write_setup(w, h, n);
      no_gaps = ($urandom_range(0, 2) == 0);
      sent = 0;
      while (sent < 17) begin
        if ($urandom_range(0, 19) == 0) begin
          wait_redraws();
        end
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        random_request(w, h, n, gap, counted);
        if (counted) begin
          sent++;
        end
      end
    end

    wait_redraws();
    repeat (HOLD_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && redraws_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/drt_pkg.sv
rtl/dirty_rectangle_tracker_top.sv
rtl/drt_checker.sv
tb/dirty_rectangle_checker.sv
tb/dirty_rectangle_tracker_top_tb.sv
